// File: design/ehnl_pkg.sv
// ehnl_pkg: widths, register indexes, reset values and sequencer states
// shared by the ecg filter chain top level and its multiplier unit
// no dependencies
package ehnl_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 24;
    localparam int MUL_COEF_W = COEF_W + 1;
    localparam int SIG_W      = 32;
    localparam int OUT_W      = 24;
    localparam int PROD_W     = MUL_COEF_W + SIG_W;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_HIGHPASS_POLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NOTCH_GAIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NOTCH_A1      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NOTCH_A2      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWPASS_GAIN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWPASS_A1    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWPASS_A2    = 3'd6;

    localparam logic signed [COEF_W-1:0] RST_HIGHPASS_POLE = 24'sd4166655;
    localparam logic signed [COEF_W-1:0] RST_NOTCH_GAIN    = 24'sd4145055;
    localparam logic signed [COEF_W-1:0] RST_NOTCH_A1      = -24'sd5813540;
    localparam logic signed [COEF_W-1:0] RST_NOTCH_A2      = 24'sd4095801;
    localparam logic signed [COEF_W-1:0] RST_LOWPASS_GAIN  = 24'sd211334;
    localparam logic signed [COEF_W-1:0] RST_LOWPASS_A1    = -24'sd5336773;
    localparam logic signed [COEF_W-1:0] RST_LOWPASS_A2    = 24'sd1987799;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HP_DIFF,
        ST_HP_MUL,
        ST_HP_OUT,
        ST_NY_MUL,
        ST_NY,
        ST_NZ1_A,
        ST_NZ1_B,
        ST_NZ_UPD,
        ST_LY,
        ST_LZ1_A,
        ST_LZ1_B,
        ST_LZ_UPD
    } state_t;

    typedef struct packed {
        logic                  en;
        logic [MUL_COEF_W-1:0] coef;
        logic [SIG_W-1:0]      sig;
    } mul_req_t;

endpackage

// File: design/ehnl_mul.sv
// ehnl_mul: shared registered coefficient by signal multiplier
// splits the product into its floor at signal scale and the rounding bit
// depends on ehnl_pkg
module ehnl_mul
    import ehnl_pkg::*;
#(
    parameter int COEF_FRAC_BITS = 22
)
(
    input  logic                                    clk,
    input  mul_req_t                                req,
    output logic signed [PROD_W-COEF_FRAC_BITS-1:0] quot,
    output logic                                    round_bit
);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    always_comb
    begin
        prod_next = $signed(req.coef) * $signed(req.sig);
    end

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign quot      = $signed(prod_reg[PROD_W-1:COEF_FRAC_BITS]);
    assign round_bit = prod_reg[COEF_FRAC_BITS-1];

endmodule

// File: design/ecg_highpass_notch_lowpass_chain.sv
// ecg_highpass_notch_lowpass_chain: one-pole high-pass, notch biquad and
// low-pass biquad on a single shared multiplier under a step sequencer
// depends on ehnl_pkg and ehnl_mul
//
// usage:
//   s_tdata carries one signed adc sample per transfer, m_tdata one filtered
//   signed q16.8 sample saturated to 24 bits, one result per sample.
//   coefficients are written through cfg_we / cfg_index / cfg_data while the
//   block is idle; index 7 is ignored.
// sequencing:
//   an accepted sample walks through 12 sequencer steps, nine of them share
//   the one 25x32 multiplier; the result is registered on the last step,
//   where m_tvalid is set. s_tready is high only in the idle step, so a new
//   sample is taken only after the last step for the previous one.
// reset:
//   rst_n clears the sequencer, the output valid, all filter state and loads
//   the default coefficients.
// stall:
//   the output register frees the input side: a new sample is taken while a
//   result waits. if the next result is ready before the previous one left,
//   the last step holds until m_tready takes the waiting transfer.
module ecg_highpass_notch_lowpass_chain
    import ehnl_pkg::*;
#(
    parameter int COEF_FRAC_BITS   = 22,
    parameter int SIGNAL_FRAC_BITS = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,   // [15:0] sample
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,   // [23:0] filtered
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [COEF_W-1:0]     cfg_data
);

    localparam int Q_W   = PROD_W - COEF_FRAC_BITS;
    localparam int ACC_W = ((Q_W > SIG_W) ? Q_W : SIG_W) + 2;

    function automatic logic signed [ACC_W-1:0] acc_op(
        input logic signed [ACC_W-1:0] a,
        input logic signed [Q_W-1:0]   q,
        input logic                    rb,
        input logic                    sub
    );
        logic signed [ACC_W-1:0] r;
        r = ACC_W'(q) + ACC_W'({1'b0, rb});
        return sub ? (a - r) : (a + r);
    endfunction

    function automatic logic signed [SIG_W-1:0] sat_sig(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-SIG_W:0] top;
        top = v[ACC_W-1:SIG_W-1];
        if (top == '0 || top == '1)
            return v[SIG_W-1:0];
        else if (v[ACC_W-1])
            return {1'b1, {(SIG_W-1){1'b0}}};
        else
            return {1'b0, {(SIG_W-1){1'b1}}};
    endfunction

    function automatic logic [OUT_W-1:0] sat_out(input logic signed [SIG_W-1:0] v);
        logic [SIG_W-OUT_W:0] top;
        top = v[SIG_W-1:OUT_W-1];
        if (top == '0 || top == '1)
            return v[OUT_W-1:0];
        else if (v[SIG_W-1])
            return {1'b1, {(OUT_W-1){1'b0}}};
        else
            return {1'b0, {(OUT_W-1){1'b1}}};
    endfunction

    state_t state_reg, state_next;

    logic signed [COEF_W-1:0] hp_pole_reg, n_gain_reg, n_a1_reg, n_a2_reg;
    logic signed [COEF_W-1:0] l_gain_reg, l_a1_reg, l_a2_reg;

    logic signed [SIG_W-1:0] hp_prev_out_reg, hp_prev_in_reg;
    logic signed [SIG_W-1:0] n_d1_reg, n_d2_reg, l_d1_reg, l_d2_reg;

    logic signed [SIG_W-1:0] x_reg, diff_reg, hp_reg, ny_reg, ly_reg;
    logic signed [ACC_W-1:0] feed_reg, acc_reg;

    logic              m_tvalid_reg;
    logic [OUT_W-1:0]  m_tdata_reg;
    logic              out_free;

    mul_req_t                mul_req;
    logic signed [Q_W-1:0]   quot;
    logic                    round_bit;
    logic signed [ACC_W-1:0] diff_sum;

    ehnl_mul #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_mul (
        .clk       (clk),
        .req       (mul_req),
        .quot      (quot),
        .round_bit (round_bit)
    );

    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign diff_sum = ACC_W'(hp_prev_out_reg) + ACC_W'(x_reg) - ACC_W'(hp_prev_in_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (s_tvalid) state_next = ST_HP_DIFF;
            ST_HP_DIFF: state_next = ST_HP_MUL;
            ST_HP_MUL:  state_next = ST_HP_OUT;
            ST_HP_OUT:  state_next = ST_NY_MUL;
            ST_NY_MUL:  state_next = ST_NY;
            ST_NY:      state_next = ST_NZ1_A;
            ST_NZ1_A:   state_next = ST_NZ1_B;
            ST_NZ1_B:   state_next = ST_NZ_UPD;
            ST_NZ_UPD:  state_next = ST_LY;
            ST_LY:      state_next = ST_LZ1_A;
            ST_LZ1_A:   state_next = ST_LZ1_B;
            ST_LZ1_B:   state_next = ST_LZ_UPD;
            ST_LZ_UPD:  if (out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // multiplier operands and handshake
    always_comb
    begin
        s_tready     = 1'b0;
        mul_req.en   = 1'b1;
        mul_req.coef = '0;
        mul_req.sig  = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready   = 1'b1;
                mul_req.en = 1'b0;
            end
            ST_HP_MUL:
            begin
                mul_req.coef = MUL_COEF_W'(hp_pole_reg);
                mul_req.sig  = diff_reg;
            end
            ST_NY_MUL:
            begin
                mul_req.coef = MUL_COEF_W'(n_gain_reg);
                mul_req.sig  = hp_reg;
            end
            ST_NY:
            begin
                mul_req.coef = MUL_COEF_W'(n_a1_reg);
                mul_req.sig  = hp_reg;
            end
            ST_NZ1_A:
            begin
                mul_req.coef = MUL_COEF_W'(n_a1_reg);
                mul_req.sig  = ny_reg;
            end
            ST_NZ1_B:
            begin
                mul_req.coef = MUL_COEF_W'(n_a2_reg);
                mul_req.sig  = ny_reg;
            end
            ST_NZ_UPD:
            begin
                mul_req.coef = MUL_COEF_W'(l_gain_reg);
                mul_req.sig  = ny_reg;
            end
            ST_LY:
            begin
                mul_req.coef = {l_gain_reg, 1'b0};
                mul_req.sig  = ny_reg;
            end
            ST_LZ1_A:
            begin
                mul_req.coef = MUL_COEF_W'(l_a1_reg);
                mul_req.sig  = ly_reg;
            end
            ST_LZ1_B:
            begin
                mul_req.coef = MUL_COEF_W'(l_a2_reg);
                mul_req.sig  = ly_reg;
            end
            ST_HP_DIFF, ST_HP_OUT, ST_LZ_UPD:
            begin
                mul_req.en = 1'b0;
            end
            default:
            begin
                mul_req.en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // coefficient registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hp_pole_reg <= RST_HIGHPASS_POLE;
            n_gain_reg  <= RST_NOTCH_GAIN;
            n_a1_reg    <= RST_NOTCH_A1;
            n_a2_reg    <= RST_NOTCH_A2;
            l_gain_reg  <= RST_LOWPASS_GAIN;
            l_a1_reg    <= RST_LOWPASS_A1;
            l_a2_reg    <= RST_LOWPASS_A2;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HIGHPASS_POLE: hp_pole_reg <= cfg_data;
                CFG_NOTCH_GAIN:    n_gain_reg  <= cfg_data;
                CFG_NOTCH_A1:      n_a1_reg    <= cfg_data;
                CFG_NOTCH_A2:      n_a2_reg    <= cfg_data;
                CFG_LOWPASS_GAIN:  l_gain_reg  <= cfg_data;
                CFG_LOWPASS_A1:    l_a1_reg    <= cfg_data;
                CFG_LOWPASS_A2:    l_a2_reg    <= cfg_data;
                default:           ;
            endcase
        end
    end

    // filter state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hp_prev_out_reg <= '0;
            hp_prev_in_reg  <= '0;
            n_d1_reg        <= '0;
            n_d2_reg        <= '0;
            l_d1_reg        <= '0;
            l_d2_reg        <= '0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_LZ_UPD && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_HP_OUT:
                begin
                    hp_prev_out_reg <= sat_sig(acc_op('0, quot, round_bit, 1'b0));
                    hp_prev_in_reg  <= x_reg;
                end
                ST_NZ_UPD:
                begin
                    n_d1_reg <= sat_sig(acc_reg);
                    n_d2_reg <= sat_sig(acc_op(feed_reg, quot, round_bit, 1'b1));
                end
                ST_LZ_UPD:
                begin
                    if (out_free)
                    begin
                        l_d1_reg <= sat_sig(acc_reg);
                        l_d2_reg <= sat_sig(acc_op(feed_reg, quot, round_bit, 1'b1));
                    end
                end
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                m_tdata_reg <= m_tdata_reg;
                if (s_tvalid)
                begin
                    x_reg <= SIG_W'($signed(s_tdata)) <<< SIGNAL_FRAC_BITS;
                end
            end
            ST_HP_DIFF: diff_reg <= sat_sig(diff_sum);
            ST_HP_OUT:  hp_reg   <= sat_sig(acc_op('0, quot, round_bit, 1'b0));
            ST_NY:
            begin
                feed_reg <= acc_op('0, quot, round_bit, 1'b0);
                ny_reg   <= sat_sig(acc_op(ACC_W'(n_d1_reg), quot, round_bit, 1'b0));
            end
            ST_NZ1_A:   acc_reg <= acc_op(ACC_W'(n_d2_reg), quot, round_bit, 1'b0);
            ST_NZ1_B:   acc_reg <= acc_op(acc_reg, quot, round_bit, 1'b1);
            ST_LY:
            begin
                feed_reg <= acc_op('0, quot, round_bit, 1'b0);
                ly_reg   <= sat_sig(acc_op(ACC_W'(l_d1_reg), quot, round_bit, 1'b0));
            end
            ST_LZ1_A:   acc_reg <= acc_op(ACC_W'(l_d2_reg), quot, round_bit, 1'b0);
            ST_LZ1_B:   acc_reg <= acc_op(acc_reg, quot, round_bit, 1'b1);
            ST_LZ_UPD:
            begin
                if (out_free)
                begin
                    m_tdata_reg <= sat_out(ly_reg);
                end
            end
            default: ;
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> state_reg == ST_HP_DIFF)
        else $error("accepted sample did not start the sequence");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> !s_tready)
        else $error("input ready while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LZ_UPD && !out_free |=> state_reg == ST_LZ_UPD && m_tvalid)
        else $error("last step left while the output was blocked");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LZ_UPD && out_free |=> m_tvalid && state_reg == ST_IDLE)
        else $error("result not presented after the last step");

endmodule

// File: bench/tb.sv
// tb: self-checking bench for the ecg high-pass, notch and low-pass chain,
// with its own bit-exact filter predictor, random stalls and coefficient sets
// depends on ehnl_pkg and ecg_highpass_notch_lowpass_chain
`timescale 1ns / 1ps

module tb;
    import ehnl_pkg::*;

    localparam int COEF_FRAC   = 22;
    localparam int SIG_FRAC    = 8;
    localparam int NUM_COEFS   = 7;
    localparam int SETTLE      = 16;
    localparam int LONG_HOLD   = 160;
    localparam int CYCLE_LIMIT = 120000;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    localparam logic signed [COEF_W-1:0] COEF_MAX = 24'sh7fffff;
    localparam logic signed [COEF_W-1:0] COEF_MIN = 24'sh800000;

    localparam logic [15:0] SAMPLE_MAX = 16'h7fff;
    localparam logic [15:0] SAMPLE_MIN = 16'h8000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [15:0]          s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [23:0]          m_tdata;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [COEF_W-1:0]    cfg_data = '0;

    logic signed [COEF_W-1:0] coef_q22 [NUM_COEFS];
    logic signed [COEF_W-1:0] next_coefs [NUM_COEFS];
    logic signed [SIG_W-1:0]  hp_y1, hp_x1, notch_s1, notch_s2, lp_s1, lp_s2;

    logic [23:0] expected_filtered [$];
    int          mismatches = 0;
    int          cycle_count = 0;
    int          stall_requests = 0;
    int          stalls_served = 0;
    int          ready_hold = 0;
    bit          no_gaps = 1'b0;

    ecg_highpass_notch_lowpass_chain i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),     // [15:0] sample
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),     // [23:0] filtered
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic longint sat_to(input longint v, input int w);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    // product rounded half up to the signal step
    function automatic longint scale_round(input longint c, input longint s);
        longint v;
        v = c * s + (64'sd1 <<< (COEF_FRAC - 1));
        return v >>> COEF_FRAC;
    endfunction

    function automatic void clear_filter_state();
        hp_y1    = '0;
        hp_x1    = '0;
        notch_s1 = '0;
        notch_s2 = '0;
        lp_s1    = '0;
        lp_s2    = '0;
        coef_q22[CFG_HIGHPASS_POLE] = RST_HIGHPASS_POLE;
        coef_q22[CFG_NOTCH_GAIN]    = RST_NOTCH_GAIN;
        coef_q22[CFG_NOTCH_A1]      = RST_NOTCH_A1;
        coef_q22[CFG_NOTCH_A2]      = RST_NOTCH_A2;
        coef_q22[CFG_LOWPASS_GAIN]  = RST_LOWPASS_GAIN;
        coef_q22[CFG_LOWPASS_A1]    = RST_LOWPASS_A1;
        coef_q22[CFG_LOWPASS_A2]    = RST_LOWPASS_A2;
    endfunction

    function automatic logic [23:0] filter_sample(input logic [15:0] sample);
        longint x, d, hp, ny, nz1, nz2, ly, lz1, lz2;
        longint hp_a, n_b0, n_a1, n_a2, l_b0, l_b1, l_a1, l_a2;
        hp_a = coef_q22[CFG_HIGHPASS_POLE];
        n_b0 = coef_q22[CFG_NOTCH_GAIN];
        n_a1 = coef_q22[CFG_NOTCH_A1];
        n_a2 = coef_q22[CFG_NOTCH_A2];
        l_b0 = coef_q22[CFG_LOWPASS_GAIN];
        l_b1 = 2 * l_b0;
        l_a1 = coef_q22[CFG_LOWPASS_A1];
        l_a2 = coef_q22[CFG_LOWPASS_A2];

        x = sat_to(longint'($signed(sample)) * (64'sd1 <<< SIG_FRAC), SIG_W);

        d  = sat_to(longint'(hp_y1) + x - longint'(hp_x1), SIG_W);
        hp = sat_to(scale_round(hp_a, d), SIG_W);
        hp_y1 = SIG_W'(hp);
        hp_x1 = SIG_W'(x);

        ny  = sat_to(scale_round(n_b0, hp) + longint'(notch_s1), SIG_W);
        nz1 = sat_to(scale_round(n_a1, hp) - scale_round(n_a1, ny)
                     + longint'(notch_s2), SIG_W);
        nz2 = sat_to(scale_round(n_b0, hp) - scale_round(n_a2, ny), SIG_W);
        notch_s1 = SIG_W'(nz1);
        notch_s2 = SIG_W'(nz2);

        ly  = sat_to(scale_round(l_b0, ny) + longint'(lp_s1), SIG_W);
        lz1 = sat_to(scale_round(l_b1, ny) - scale_round(l_a1, ly)
                     + longint'(lp_s2), SIG_W);
        lz2 = sat_to(scale_round(l_b0, ny) - scale_round(l_a2, ly), SIG_W);
        lp_s1 = SIG_W'(lz1);
        lp_s2 = SIG_W'(lz2);

        return OUT_W'(sat_to(ly, OUT_W));
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        logic [23:0] want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_filtered.size() == 0)
                report_mismatch($sformatf("unexpected transfer, filtered %0d",
                                          $signed(m_tdata)));
            else
            begin
                want = expected_filtered.pop_front();
                if (m_tdata !== want)
                    report_mismatch($sformatf("filtered got %0d want %0d",
                                              $signed(m_tdata), $signed(want)));
            end
        end
    end

    // receiver: random hold after each transfer, long hold on request
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
            ready_hold = no_gaps ? 0 : $urandom_range(0, 4);
        if (stall_requests != stalls_served)
        begin
            stalls_served++;
            ready_hold = LONG_HOLD;
        end
        if (ready_hold > 0)
        begin
            ready_hold--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results pending",
                 cycle_count, expected_filtered.size());
        $display("== FAIL ==");
        $finish;
    end

    task automatic send_sample(input logic [15:0] value);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_filtered.push_back(filter_sample(value));
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_filtered.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [COEF_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        if (idx <= CFG_LOWPASS_A2)
            coef_q22[idx] = data;
    endtask

    task automatic load_coefs();
        wait_idle();
        for (int i = 0; i < NUM_COEFS; i++)
            write_reg(CFG_IDX_W'(i), next_coefs[i]);
        cfg_we <= 1'b0;
    endtask

    task automatic fill_coefs(input logic signed [COEF_W-1:0] value);
        for (int i = 0; i < NUM_COEFS; i++)
            next_coefs[i] = value;
    endtask

    function automatic logic [15:0] random_sample(input logic [15:0] prev);
        int pick;
        pick = $urandom_range(0, 9);
        if (pick <= 3)
            return 16'($urandom());
        if (pick <= 6)
            return 16'(int'($urandom_range(0, 4000)) - 2000);
        if (pick == 7)
            return $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
        if (pick == 8)
            return prev;
        return '0;
    endfunction

    task automatic test_reset_defaults();
        send_sample('0);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MIN);
        send_sample(16'h0001);
        send_sample(16'hffff);
        send_sample('0);
    endtask

    // a write to the unused index must leave every coefficient alone
    task automatic test_unused_index();
        wait_idle();
        write_reg(CFG_UNUSED, COEF_W'($urandom()));
        cfg_we <= 1'b0;
        send_sample(16'h1234);
        send_sample(SAMPLE_MIN);
    endtask

    // full-scale coefficients of both signs to reach saturation, then all zeros
    task automatic test_extreme_coefs();
        fill_coefs(COEF_MAX);
        load_coefs();
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MAX);
        fill_coefs(COEF_MIN);
        load_coefs();
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MAX);
        fill_coefs('0);
        load_coefs();
        send_sample(16'd12345);
        send_sample(16'hffff);
    endtask

    task automatic test_random_phases();
        logic [15:0] prev;
        int          pick;
        prev = '0;
        for (int phase = 0; phase < 9; phase++)
        begin
            for (int i = 0; i < NUM_COEFS; i++)
            begin
                case (phase % 4)
                    0: next_coefs[i] = '0;
                    1: next_coefs[i] = COEF_W'($urandom());
                    2: next_coefs[i] = '0;
                    default:
                    begin
                        pick = $urandom_range(0, 2);
                        next_coefs[i] = (pick == 0) ? COEF_MAX :
                                        (pick == 1) ? COEF_MIN : COEF_W'($urandom());
                    end
                endcase
            end
            if (phase % 2 == 0)
            begin
                // stable sets near the design point, jittered except in the first
                next_coefs[CFG_HIGHPASS_POLE] = RST_HIGHPASS_POLE;
                next_coefs[CFG_NOTCH_GAIN]    = RST_NOTCH_GAIN;
                next_coefs[CFG_NOTCH_A1]      = RST_NOTCH_A1;
                next_coefs[CFG_NOTCH_A2]      = RST_NOTCH_A2;
                next_coefs[CFG_LOWPASS_GAIN]  = RST_LOWPASS_GAIN;
                next_coefs[CFG_LOWPASS_A1]    = RST_LOWPASS_A1;
                next_coefs[CFG_LOWPASS_A2]    = RST_LOWPASS_A2;
                if (phase != 0)
                    for (int i = 0; i < NUM_COEFS; i++)
                        next_coefs[i] = COEF_W'(int'(next_coefs[i])
                                        + int'($urandom_range(0, 65535)) - 32768);
            end
            load_coefs();
            no_gaps = (phase == 4);
            for (int n = 0; n < 58; n++)
            begin
                prev = random_sample(prev);
                send_sample(prev);
            end
            no_gaps = 1'b0;
        end
    endtask

    // receiver holds off while samples keep coming, so the input side stalls
    task automatic test_backpressure();
        wait_idle();
        no_gaps = 1'b1;
        stall_requests++;
        for (int n = 0; n < 24; n++)
            send_sample(16'($urandom()));
        no_gaps = 1'b0;
    endtask

    initial
    begin
        clear_filter_state();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_unused_index();
        test_extreme_coefs();
        test_backpressure();
        test_random_phases();

        s_tvalid <= 1'b0;
        while (expected_filtered.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: files.f
design/ehnl_pkg.sv
design/ehnl_mul.sv
design/ecg_highpass_notch_lowpass_chain.sv
bench/tb.sv
